[hw/rtl/rdas_pkg.sv]
package rdas_pkg;

    typedef enum logic [1:0] {
        CMD_INSERT = 2'd0,
        CMD_REMOVE = 2'd1,
        CMD_QUERY  = 2'd2
    } t_cmd;

    localparam logic [2:0] ST_STORED   = 3'd0;
    localparam logic [2:0] ST_MISS     = 3'd1;
    localparam logic [2:0] ST_FULL     = 3'd2;
    localparam logic [2:0] ST_REMOVED  = 3'd3;
    localparam logic [2:0] ST_NOTFOUND = 3'd4;

    localparam logic CFG_OBS_X = 1'b0;
    localparam logic CFG_OBS_Y = 1'b1;

    typedef enum logic [1:0] {
        OP_INSERT,
        OP_MISS,
        OP_REMOVE,
        OP_QUERY
    } t_op_kind;

    typedef struct packed {
        t_op_kind    kind;
        logic [15:0] id;
        logic [31:0] distance;
    } t_op;

    typedef struct packed {
        logic [15:0] id;
        logic [31:0] distance;
    } t_entry;

    localparam int CORDIC_STEPS = 24;
    localparam logic signed [33:0] CORDIC_X0 = 34'sd652032874;

    function automatic logic [31:0] atan_turn(input logic [4:0] i);
        logic [31:0] v;
        case (i)
            5'd0:  v = 32'h20000000;
            5'd1:  v = 32'h12E4051E;
            5'd2:  v = 32'h09FB385B;
            5'd3:  v = 32'h051111D4;
            5'd4:  v = 32'h028B0D43;
            5'd5:  v = 32'h0145D7E1;
            5'd6:  v = 32'h00A2F61E;
            5'd7:  v = 32'h00517C55;
            5'd8:  v = 32'h0028BE53;
            5'd9:  v = 32'h00145F2F;
            5'd10: v = 32'h000A2F98;
            5'd11: v = 32'h000517CC;
            5'd12: v = 32'h00028BE6;
            5'd13: v = 32'h000145F3;
            5'd14: v = 32'h0000A2FA;
            5'd15: v = 32'h0000517D;
            5'd16: v = 32'h000028BE;
            5'd17: v = 32'h0000145F;
            5'd18: v = 32'h00000A30;
            5'd19: v = 32'h00000518;
            5'd20: v = 32'h0000028C;
            5'd21: v = 32'h00000146;
            5'd22: v = 32'h000000A3;
            5'd23: v = 32'h00000051;
            default: v = 32'h0;
        endcase
        return v;
    endfunction

endpackage

[hw/rtl/rdas_ram.sv]
module rdas_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

[hw/rtl/rdas_front.sv]
module rdas_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [1:0]         i_command,
    input  logic [15:0]        i_segment_id,
    input  logic signed [31:0] i_end_a_x,
    input  logic signed [31:0] i_end_a_y,
    input  logic signed [31:0] i_end_b_x,
    input  logic signed [31:0] i_end_b_y,
    input  logic [15:0]        i_sweep_angle,
    input  logic signed [31:0] i_obs_x,
    input  logic signed [31:0] i_obs_y,
    output rdas_pkg::t_op      o_op,
    output logic               o_push,
    input  logic               i_full
);
    typedef enum logic [2:0] {
        S_IDLE, S_ROT, S_MUL, S_NORM, S_TEST, S_DIV, S_PUSH
    } t_state;

    t_state r_state;
    rdas_pkg::t_op_kind r_kind;
    logic [15:0] r_id;
    logic signed [32:0] r_dsx, r_dsy, r_dpx, r_dpy;
    logic signed [33:0] r_x, r_y, r_z;
    logic [1:0] r_quad;
    logic [4:0] r_k;
    logic signed [65:0] r_prod;
    logic signed [53:0] r_det, r_nu;
    logic signed [66:0] r_nt;
    logic [55:0] r_rem;
    logic [31:0] r_lo, r_q;

    // angle reduction to +-1/8 turn
    logic [33:0] w_full, w_ksum;
    logic signed [33:0] w_z0;
    assign w_full = {2'b00, i_sweep_angle, 16'h0000};
    assign w_ksum = w_full + 34'h020000000;
    assign w_z0 = $signed(w_full - {w_ksum[33:30], 30'h0});

    logic signed [33:0] w_xs, w_ys, w_at, w_xr, w_yr;
    logic signed [19:0] w_c, w_s, w_xc, w_yc;
    assign w_xs = r_x >>> r_k;
    assign w_ys = r_y >>> r_k;
    assign w_at = $signed({2'b00, rdas_pkg::atan_turn(r_k)});
    assign w_xr = (r_x + 34'sd32768) >>> 16;
    assign w_yr = (r_y + 34'sd32768) >>> 16;
    assign w_xc = w_xr[19:0];
    assign w_yc = w_yr[19:0];

    always_comb begin
        case (r_quad)
            2'd0: begin w_c = w_xc;  w_s = w_yc;  end
            2'd1: begin w_c = -w_yc; w_s = w_xc;  end
            2'd2: begin w_c = -w_xc; w_s = -w_yc; end
            default: begin w_c = w_yc; w_s = -w_xc; end
        endcase
    end

    logic signed [32:0] w_ma, w_mb, w_cx, w_sx;
    logic signed [65:0] w_prod;
    assign w_cx = 33'(w_c);
    assign w_sx = 33'(w_s);

    always_comb begin
        case (r_k)
            5'd0: begin w_ma = w_cx;  w_mb = r_dsy; end
            5'd1: begin w_ma = w_sx;  w_mb = r_dsx; end
            5'd2: begin w_ma = r_dpx; w_mb = w_sx;  end
            5'd3: begin w_ma = r_dpy; w_mb = w_cx;  end
            5'd4: begin w_ma = r_dpx; w_mb = r_dsy; end
            default: begin w_ma = r_dpy; w_mb = r_dsx; end
        endcase
    end
    assign w_prod = w_ma * w_mb;

    logic [71:0] w_ntu, w_lim;
    logic w_hit;
    logic [56:0] w_rs, w_dd;
    logic w_ge;
    assign w_ntu = {5'h00, r_nt};
    assign w_lim = {r_det, 18'h00000};
    assign w_hit = !r_nt[66] && !r_nu[53] && (r_nu <= r_det);
    assign w_rs = {r_rem, r_lo[31]};
    assign w_dd = {3'b000, r_det};
    assign w_ge = (w_rs >= w_dd);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            unique case (r_state)
                S_IDLE: if (i_valid) begin
                    r_id  <= i_segment_id;
                    r_dsx <= 33'(i_end_b_x) - 33'(i_end_a_x);
                    r_dsy <= 33'(i_end_b_y) - 33'(i_end_a_y);
                    r_dpx <= 33'(i_end_a_x) - 33'(i_obs_x);
                    r_dpy <= 33'(i_end_a_y) - 33'(i_obs_y);
                    r_x <= rdas_pkg::CORDIC_X0;
                    r_y <= '0;
                    r_z <= w_z0;
                    r_quad <= w_ksum[31:30];
                    r_k <= '0;
                    r_q <= '0;
                    case (i_command)
                        rdas_pkg::CMD_INSERT: begin
                            r_kind <= rdas_pkg::OP_INSERT;
                            r_state <= S_ROT;
                        end
                        rdas_pkg::CMD_REMOVE: begin
                            r_kind <= rdas_pkg::OP_REMOVE;
                            r_state <= S_PUSH;
                        end
                        default: begin
                            r_kind <= rdas_pkg::OP_QUERY;
                            r_state <= S_PUSH;
                        end
                    endcase
                end
                S_ROT: begin
                    if (!r_z[33]) begin
                        r_x <= r_x - w_ys;
                        r_y <= r_y + w_xs;
                        r_z <= r_z - w_at;
                    end else begin
                        r_x <= r_x + w_ys;
                        r_y <= r_y - w_xs;
                        r_z <= r_z + w_at;
                    end
                    if (r_k == 5'(rdas_pkg::CORDIC_STEPS - 1)) begin
                        r_k <= '0;
                        r_state <= S_MUL;
                    end else begin
                        r_k <= r_k + 5'd1;
                    end
                end
                S_MUL: begin
                    r_prod <= w_prod;
                    // consume the product of the previous step
                    case (r_k)
                        5'd1: r_det <= r_prod[53:0];
                        5'd2: r_det <= r_det - r_prod[53:0];
                        5'd3: r_nu <= r_prod[53:0];
                        5'd4: r_nu <= r_nu - r_prod[53:0];
                        5'd5: r_nt <= {r_prod[65], r_prod};
                        5'd6: r_nt <= r_nt - {r_prod[65], r_prod};
                        default: ;
                    endcase
                    if (r_k == 5'd6) begin
                        r_state <= S_NORM;
                    end
                    r_k <= r_k + 5'd1;
                end
                S_NORM: begin
                    if (r_det == '0) begin
                        r_kind <= rdas_pkg::OP_MISS;
                        r_state <= S_PUSH;
                    end else begin
                        if (r_det[53]) begin
                            r_det <= -r_det;
                            r_nu <= -r_nu;
                            r_nt <= -r_nt;
                        end
                        r_state <= S_TEST;
                    end
                end
                S_TEST: begin
                    r_k <= '0;
                    if (!w_hit) begin
                        r_kind <= rdas_pkg::OP_MISS;
                        r_state <= S_PUSH;
                    end else if (w_ntu >= w_lim) begin
                        r_q <= '1;
                        r_state <= S_PUSH;
                    end else begin
                        r_rem <= {7'h00, r_nt[66:18]};
                        r_lo <= {r_nt[17:0], 14'h0000};
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    r_rem <= w_ge ? 56'(w_rs - w_dd) : w_rs[55:0];
                    r_q <= {r_q[30:0], w_ge};
                    r_lo <= {r_lo[30:0], 1'b0};
                    r_k <= r_k + 5'd1;
                    if (r_k == 5'd31) begin
                        r_state <= S_PUSH;
                    end
                end
                S_PUSH: if (!i_full) begin
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_stall = (r_state != S_IDLE);
    assign o_push = (r_state == S_PUSH) && !i_full;
    assign o_op.kind = r_kind;
    assign o_op.id = r_id;
    assign o_op.distance = r_q;
endmodule

[hw/rtl/rdas_queue.sv]
module rdas_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  rdas_pkg::t_op i_op,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_nonempty,
    output rdas_pkg::t_op o_op
);
    rdas_pkg::t_op r_slot [2];
    logic r_wp, r_rp;
    logic [1:0] r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0;
            r_rp <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_slot[r_wp] <= i_op;
                r_wp <= !r_wp;
            end
            if (i_pop) begin
                r_rp <= !r_rp;
            end
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end

    assign o_full = (r_cnt == 2'd2);
    assign o_nonempty = (r_cnt != 2'd0);
    assign o_op = r_slot[r_rp];
endmodule

[hw/rtl/rdas_back.sv]
module rdas_back #(
    parameter int CAPACITY = 64
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  rdas_pkg::t_op i_op,
    input  logic          i_nonempty,
    output logic          o_pop,
    output logic          o_valid,
    input  logic          i_stall,
    output logic [2:0]    o_status,
    output logic          o_nearest_valid,
    output logic [15:0]   o_nearest_id,
    output logic [31:0]   o_nearest_distance,
    output logic [6:0]    o_entry_total
);
    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);

    typedef enum logic [3:0] {
        B_IDLE, B_INS_RD, B_INS_CHK, B_INS_PUT, B_REM_RD, B_REM_CHK,
        B_SH_RD, B_SH_WR, B_HEAD_RD, B_HEAD_CHK, B_FIN
    } t_state;

    t_state r_state;
    logic [CW-1:0] r_count;
    logic [AW-1:0] r_idx, r_pos;
    logic [15:0] r_id;
    logic [31:0] r_dist;
    logic [2:0] r_status;
    logic [15:0] r_head_id;
    logic [31:0] r_head_dist;

    logic w_we;
    logic [AW-1:0] w_waddr, w_raddr;
    rdas_pkg::t_entry w_wdata, w_rdata;
    logic [CW-1:0] w_idx1, w_idx2;
    logic [31:0] w_tot;

    assign w_idx1 = CW'(r_idx) + CW'(1);
    assign w_idx2 = CW'(r_idx) + CW'(2);
    assign w_tot = 32'(r_count);

    rdas_ram #(.WIDTH($bits(rdas_pkg::t_entry)), .DEPTH(CAPACITY)) u_ram (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(w_waddr),
        .i_wdata(w_wdata),
        .i_raddr(w_raddr),
        .o_rdata(w_rdata)
    );

    always_comb begin
        w_we = 1'b0;
        w_waddr = r_idx;
        w_wdata = w_rdata;
        w_raddr = r_idx;
        case (r_state)
            B_INS_CHK: begin
                w_we = 1'b1;
                w_waddr = r_idx + AW'(1);
                if (w_rdata.distance <= r_dist) begin
                    w_wdata.id = r_id;
                    w_wdata.distance = r_dist;
                end
            end
            B_INS_PUT: begin
                w_we = 1'b1;
                w_waddr = r_pos;
                w_wdata.id = r_id;
                w_wdata.distance = r_dist;
            end
            B_SH_RD: w_raddr = r_idx + AW'(1);
            B_SH_WR: w_we = 1'b1;
            B_HEAD_RD: w_raddr = '0;
            default: ;
        endcase
    end

    assign o_pop = (r_state == B_IDLE) && i_nonempty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_IDLE;
            r_count <= '0;
            o_valid <= 1'b0;
        end else begin
            if (o_valid && !i_stall && r_state != B_FIN) begin
                o_valid <= 1'b0;
            end
            unique case (r_state)
                B_IDLE: if (i_nonempty) begin
                    r_id <= i_op.id;
                    r_dist <= i_op.distance;
                    r_pos <= '0;
                    case (i_op.kind)
                        rdas_pkg::OP_MISS: begin
                            r_status <= rdas_pkg::ST_MISS;
                            r_idx <= '0;
                            r_state <= B_HEAD_RD;
                        end
                        rdas_pkg::OP_INSERT: begin
                            if (r_count == CW'(CAPACITY)) begin
                                r_status <= rdas_pkg::ST_FULL;
                                r_idx <= '0;
                                r_state <= B_HEAD_RD;
                            end else if (r_count == '0) begin
                                r_status <= rdas_pkg::ST_NOTFOUND;
                                r_idx <= '0;
                                r_state <= B_INS_PUT;
                            end else begin
                                r_status <= rdas_pkg::ST_NOTFOUND;
                                r_idx <= AW'(r_count - CW'(1));
                                r_state <= B_INS_RD;
                            end
                        end
                        rdas_pkg::OP_REMOVE: begin
                            r_status <= rdas_pkg::ST_NOTFOUND;
                            r_idx <= '0;
                            if (r_count != '0) begin
                                r_state <= B_REM_RD;
                            end else begin
                                r_state <= B_HEAD_RD;
                            end
                        end
                        default: begin
                            r_status <= rdas_pkg::ST_NOTFOUND;
                            r_idx <= '0;
                            r_state <= B_HEAD_RD;
                        end
                    endcase
                end
                B_INS_RD: r_state <= B_INS_CHK;
                // walk down from the tail, moving larger entries up one place
                B_INS_CHK: begin
                    if (w_rdata.distance > r_dist) begin
                        if (r_idx == '0) begin
                            r_pos <= '0;
                            r_state <= B_INS_PUT;
                        end else begin
                            r_idx <= r_idx - AW'(1);
                            r_state <= B_INS_RD;
                        end
                    end else begin
                        r_count <= r_count + CW'(1);
                        r_status <= rdas_pkg::ST_STORED;
                        r_state <= B_HEAD_RD;
                    end
                end
                B_INS_PUT: begin
                    r_count <= r_count + CW'(1);
                    r_status <= rdas_pkg::ST_STORED;
                    r_state <= B_HEAD_RD;
                end
                B_REM_RD: r_state <= B_REM_CHK;
                B_REM_CHK: begin
                    if (w_rdata.id == r_id) begin
                        r_status <= rdas_pkg::ST_REMOVED;
                        if (w_idx1 == r_count) begin
                            r_count <= r_count - CW'(1);
                            r_state <= B_HEAD_RD;
                        end else begin
                            r_state <= B_SH_RD;
                        end
                    end else if (w_idx1 == r_count) begin
                        r_state <= B_HEAD_RD;
                    end else begin
                        r_idx <= r_idx + AW'(1);
                        r_state <= B_REM_RD;
                    end
                end
                B_SH_RD: r_state <= B_SH_WR;
                B_SH_WR: begin
                    if (w_idx2 == r_count) begin
                        r_count <= r_count - CW'(1);
                        r_state <= B_HEAD_RD;
                    end else begin
                        r_idx <= r_idx + AW'(1);
                        r_state <= B_SH_RD;
                    end
                end
                B_HEAD_RD: r_state <= B_HEAD_CHK;
                B_HEAD_CHK: begin
                    r_head_id <= (r_count != '0) ? w_rdata.id : 16'h0000;
                    r_head_dist <= (r_count != '0) ? w_rdata.distance : 32'h0;
                    r_state <= B_FIN;
                end
                B_FIN: if (!o_valid || !i_stall) begin
                    o_valid <= 1'b1;
                    o_status <= r_status;
                    o_nearest_valid <= (r_count != '0);
                    o_nearest_id <= r_head_id;
                    o_nearest_distance <= r_head_dist;
                    o_entry_total <= w_tot[6:0];
                    r_state <= B_IDLE;
                end
                default: r_state <= B_IDLE;
            endcase
        end
    end
endmodule

[hw/rtl/ray_distance_active_segment_set_unit.sv]
// Active segment set for a visibility sweep, sorted by ray distance from
// an observer held in two configuration registers (index 0 x, index 1 y),
// written through i_cfg_valid/o_cfg_ready/i_cfg_index/i_cfg_data. The user
// writes them only while idle; the block itself leaves this unenforced.
// Input channel: i_valid/o_stall with command, id, endpoints and angle.
// Output channel: o_valid/i_stall, one result per item with status,
// nearest entry and entry count. The front end takes one item at a time:
// an insert runs a 24-step CORDIC, six shared multiplies and, unless it
// misses or saturates, a 32-step restoring divide; remove and query skip
// the arithmetic. A two-entry queue feeds the back end, which takes one
// item at a time and edits the sorted RAM one entry at a time, a read then
// a write (single read port, registered read), before reading the head.
// The result sits in an output register; while i_stall is high it holds
// and the front end keeps accepting until the queue fills.
// Synchronous active-low reset empties the set and clears the observer.
module ray_distance_active_segment_set_unit #(
    parameter int CAPACITY = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [1:0]         i_command,
    input  logic [15:0]        i_segment_id,
    input  logic signed [31:0] i_end_a_x,
    input  logic signed [31:0] i_end_a_y,
    input  logic signed [31:0] i_end_b_x,
    input  logic signed [31:0] i_end_b_y,
    input  logic [15:0]        i_sweep_angle,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [2:0]         o_status,
    output logic               o_nearest_valid,
    output logic [15:0]        o_nearest_id,
    output logic [31:0]        o_nearest_distance,
    output logic [6:0]         o_entry_total,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic               i_cfg_index,
    input  logic [31:0]        i_cfg_data
);
    logic signed [31:0] r_obs_x, r_obs_y;
    rdas_pkg::t_op w_fop, w_qop;
    logic w_push, w_full, w_pop, w_nonempty;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_obs_x <= '0;
            r_obs_y <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                rdas_pkg::CFG_OBS_X: r_obs_x <= i_cfg_data;
                default: r_obs_y <= i_cfg_data;
            endcase
        end
    end

    rdas_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .i_command(i_command), .i_segment_id(i_segment_id),
        .i_end_a_x(i_end_a_x), .i_end_a_y(i_end_a_y),
        .i_end_b_x(i_end_b_x), .i_end_b_y(i_end_b_y),
        .i_sweep_angle(i_sweep_angle), .i_obs_x(r_obs_x), .i_obs_y(r_obs_y),
        .o_op(w_fop), .o_push(w_push), .i_full(w_full)
    );

    rdas_queue u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(w_push), .i_op(w_fop),
        .o_full(w_full), .i_pop(w_pop), .o_nonempty(w_nonempty), .o_op(w_qop)
    );

    rdas_back #(.CAPACITY(CAPACITY)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_op(w_qop), .i_nonempty(w_nonempty),
        .o_pop(w_pop), .o_valid(o_valid), .i_stall(i_stall),
        .o_status(o_status), .o_nearest_valid(o_nearest_valid),
        .o_nearest_id(o_nearest_id), .o_nearest_distance(o_nearest_distance),
        .o_entry_total(o_entry_total)
    );
endmodule

[hw/rtl/rdas_checker.sv]
module rdas_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_valid,
    input logic        i_stall,
    input logic [2:0]  o_status,
    input logic        o_nearest_valid,
    input logic [15:0] o_nearest_id,
    input logic [31:0] o_nearest_distance,
    input logic [6:0]  o_entry_total
);
    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid)
        else $error("result dropped while stalled");

    a_hold_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> $stable(o_status) && $stable(o_nearest_id)
            && $stable(o_nearest_distance) && $stable(o_entry_total))
        else $error("stalled result changed");

    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_nearest_valid |-> o_nearest_id == 16'h0000
            && o_nearest_distance == 32'h0)
        else $error("empty set reports an entry");

    a_stored_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status == rdas_pkg::ST_STORED |-> o_nearest_valid)
        else $error("stored but set empty");

    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_status <= rdas_pkg::ST_NOTFOUND)
        else $error("bad status code");
endmodule

bind ray_distance_active_segment_set_unit rdas_checker u_rdas_checker (.*);

[sim/tb_top.sv]
`default_nettype none

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          SET_DEPTH   = 64;
    localparam logic [1:0]  CMD_SPARE   = 2'd3;
    localparam int          DRAIN_WAIT  = 300;
    localparam int          LONG_HOLD   = 2500;
    localparam int          PHASES      = 8;
    localparam int          PHASE_ITEMS = 215;

    localparam longint ROT_ANGLE [24] = '{
        64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43,
        64'h0145D7E1, 64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F,
        64'h000A2F98, 64'h000517CC, 64'h00028BE6, 64'h000145F3, 64'h0000A2FA,
        64'h0000517D, 64'h000028BE, 64'h0000145F, 64'h00000A30, 64'h00000518,
        64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051
    };

    typedef struct {
        logic [1:0]  cmd;
        logic [15:0] id;
        logic [31:0] ax, ay, bx, by;
        logic [15:0] ang;
    } t_seg_cmd;

    typedef struct {
        logic [2:0]  status;
        logic        nvalid;
        logic [15:0] nid;
        logic [31:0] ndist;
        logic [6:0]  total;
    } t_nearest;

    logic        i_clk, i_rst_n;
    logic        i_valid, o_stall;
    logic [1:0]  i_command;
    logic [15:0] i_segment_id;
    logic signed [31:0] i_end_a_x, i_end_a_y, i_end_b_x, i_end_b_y;
    logic [15:0] i_sweep_angle;
    logic        o_valid, i_stall;
    logic [2:0]  o_status;
    logic        o_nearest_valid;
    logic [15:0] o_nearest_id;
    logic [31:0] o_nearest_distance;
    logic [6:0]  o_entry_total;
    logic        i_cfg_valid, o_cfg_ready, i_cfg_index;
    logic [31:0] i_cfg_data;

    ray_distance_active_segment_set_unit #(.CAPACITY(SET_DEPTH)) uut (.*);

    // sorted set kept alongside the block
    logic [15:0] set_ids   [SET_DEPTH];
    logic [31:0] set_dists [SET_DEPTH];
    int          set_count;
    longint      obs_x, obs_y;

    t_seg_cmd    pending_cmds[$];
    t_nearest    expected_nearest[$];
    logic [15:0] issued_ids[$];
    t_seg_cmd    cur, last_hit;
    bit          in_took, run_live;
    int          send_idle, rx_idle;
    int          hold_asks, hold_served, hold_left;
    int          err_count, results_seen;
    int          status_hits[5];

    function automatic void sweep_trig(input logic [15:0] ang,
                                       output longint c, output longint s);
        longint full, quad, z, x, y, xs, ys;
        full = longint'(ang) << 16;
        quad = (full + 64'h20000000) >>> 30;
        z = full - (quad << 30);
        x = 652032874;
        y = 0;
        for (int i = 0; i < 24; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (z >= 0) begin
                x -= ys; y += xs; z -= ROT_ANGLE[i];
            end else begin
                x += ys; y -= xs; z += ROT_ANGLE[i];
            end
        end
        x = (x + 32768) >>> 16;
        y = (y + 32768) >>> 16;
        case (quad & 3)
            0: begin c = x;  s = y;  end
            1: begin c = -y; s = x;  end
            2: begin c = -x; s = -y; end
            default: begin c = y; s = -x; end
        endcase
    endfunction

    // ray distance in Q16.16, returns 0 on parallel ray or miss
    function automatic bit ray_distance(input t_seg_cmd it, output logic [31:0] t);
        longint c, s, dsx, dsy, dpx, dpy, det, nu;
        logic signed [127:0] w1, w2, nt;
        sweep_trig(it.ang, c, s);
        dsx = longint'($signed(it.bx)) - longint'($signed(it.ax));
        dsy = longint'($signed(it.by)) - longint'($signed(it.ay));
        dpx = longint'($signed(it.ax)) - obs_x;
        dpy = longint'($signed(it.ay)) - obs_y;
        t = '0;
        det = c * dsy - s * dsx;
        if (det == 0) return 0;
        nu = dpx * s - dpy * c;
        w1 = dpx; w2 = dsy; nt = w1 * w2;
        w1 = dpy; w2 = dsx; nt = nt - w1 * w2;
        if (det < 0) begin
            det = -det; nu = -nu; nt = -nt;
        end
        if (nt < 0 || nu < 0 || nu > det) return 0;
        w1 = det;
        if (nt >= (w1 <<< 18)) t = 32'hFFFF_FFFF;
        else begin
            w2 = (nt <<< 14) / w1;
            t = w2[31:0];
        end
        return 1;
    endfunction

    function automatic t_nearest apply_cmd(input t_seg_cmd it);
        t_nearest r;
        logic [31:0] t;
        int pos;
        r.status = rdas_pkg::ST_NOTFOUND;
        if (it.cmd == rdas_pkg::CMD_INSERT) begin
            if (!ray_distance(it, t)) r.status = rdas_pkg::ST_MISS;
            else if (set_count >= SET_DEPTH) r.status = rdas_pkg::ST_FULL;
            else begin
                pos = 0;
                while (pos < set_count && set_dists[pos] <= t) pos++;
                for (int i = set_count; i > pos; i--) begin
                    set_ids[i] = set_ids[i-1];
                    set_dists[i] = set_dists[i-1];
                end
                set_ids[pos] = it.id;
                set_dists[pos] = t;
                set_count++;
                r.status = rdas_pkg::ST_STORED;
            end
        end else if (it.cmd == rdas_pkg::CMD_REMOVE) begin
            for (pos = 0; pos < set_count; pos++)
                if (set_ids[pos] == it.id) break;
            if (pos < set_count) begin
                for (int i = pos; i + 1 < set_count; i++) begin
                    set_ids[i] = set_ids[i+1];
                    set_dists[i] = set_dists[i+1];
                end
                set_count--;
                r.status = rdas_pkg::ST_REMOVED;
            end
        end
        r.nvalid = set_count > 0;
        r.nid    = set_count > 0 ? set_ids[0] : 16'd0;
        r.ndist  = set_count > 0 ? set_dists[0] : 32'd0;
        r.total  = 7'(set_count);
        return r;
    endfunction

    // clock and watchdog timeout
    initial begin
        i_clk = 0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #50ms;
        $display("DONE: errors detected");
        $finish;
    end

    // item driver
    always @(negedge i_clk) begin
        if (run_live && (!i_valid || in_took)) begin
            if (pending_cmds.size() > 0 && $urandom_range(99) >= send_idle) begin
                cur = pending_cmds.pop_front();
                i_command     <= cur.cmd;
                i_segment_id  <= cur.id;
                i_end_a_x     <= cur.ax;
                i_end_a_y     <= cur.ay;
                i_end_b_x     <= cur.bx;
                i_end_b_y     <= cur.by;
                i_sweep_angle <= cur.ang;
                i_valid       <= 1'b1;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // receiver stall, with an occasional long hold-off
    always @(negedge i_clk) begin
        if (!run_live) begin
            i_stall <= 1'b0;
        end else if (hold_asks != hold_served) begin
            hold_served = hold_asks;
            hold_left = LONG_HOLD;
            i_stall <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left--;
            i_stall <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(99) < rx_idle);
        end
    end

    // accept tracking and result checking
    always @(posedge i_clk) begin
        t_nearest e;
        in_took = run_live && i_valid && !o_stall;
        if (in_took) expected_nearest.push_back(apply_cmd(cur));
        if (run_live && o_valid && !i_stall) begin
            results_seen++;
            if (expected_nearest.size() == 0) begin
                $error("result transfer with nothing expected");
                err_count++;
            end else begin
                e = expected_nearest.pop_front();
                if (o_status <= rdas_pkg::ST_NOTFOUND) status_hits[o_status]++;
                if (o_status !== e.status) begin
                    $error("status exp %0d got %0d", e.status, o_status);
                    err_count++;
                end
                if (o_nearest_valid !== e.nvalid) begin
                    $error("nearest_valid exp %0d got %0d", e.nvalid, o_nearest_valid);
                    err_count++;
                end
                if (o_nearest_id !== e.nid) begin
                    $error("nearest_id exp %0h got %0h", e.nid, o_nearest_id);
                    err_count++;
                end
                if (o_nearest_distance !== e.ndist) begin
                    $error("nearest_distance exp %0h got %0h", e.ndist,
                           o_nearest_distance);
                    err_count++;
                end
                if (o_entry_total !== e.total) begin
                    $error("entry_total exp %0d got %0d", e.total, o_entry_total);
                    err_count++;
                end
            end
        end
    end

    task automatic reg_write(input logic idx, input logic [31:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx == rdas_pkg::CFG_OBS_X) obs_x = longint'($signed(val));
        else obs_y = longint'($signed(val));
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic drain();
        wait (pending_cmds.size() == 0 && !i_valid && expected_nearest.size() == 0);
        repeat (20) @(posedge i_clk);
    endtask

    function automatic t_seg_cmd seg(input logic [1:0] cmd, input logic [15:0] id,
                                     input longint ax, input longint ay,
                                     input longint bx, input longint by,
                                     input logic [15:0] ang);
        t_seg_cmd it;
        it.cmd = cmd; it.id = id; it.ang = ang;
        it.ax = 32'(ax); it.ay = 32'(ay); it.bx = 32'(bx); it.by = 32'(by);
        return it;
    endfunction

    // segment placed across a ray near one of the four axes
    function automatic t_seg_cmd crossing_insert(input logic [15:0] id);
        longint d, u1, v1, u2, v2;
        int q, jit;
        t_seg_cmd it;
        q = $urandom_range(3);
        jit = $urandom_range(4000) - 2000;
        d = $urandom_range(1 << 22, 1 << 12);
        u1 = d + $urandom_range(1 << 12);
        u2 = d + $urandom_range(1 << 12);
        v1 = -(d / 2 + $urandom_range(2 * d));
        v2 = d / 2 + $urandom_range(2 * d);
        if ($urandom_range(1)) begin
            u1 = -u1; u2 = -u2; v1 = -v1; v2 = -v2; q = (q + 2) % 4;
        end
        case (q)
            0: it = seg(rdas_pkg::CMD_INSERT, id, u1, v1, u2, v2, 0);
            1: it = seg(rdas_pkg::CMD_INSERT, id, -v1, u1, -v2, u2, 0);
            2: it = seg(rdas_pkg::CMD_INSERT, id, -u1, -v1, -u2, -v2, 0);
            default: it = seg(rdas_pkg::CMD_INSERT, id, v1, -u1, v2, -u2, 0);
        endcase
        it.ax += 32'(obs_x); it.bx += 32'(obs_x);
        it.ay += 32'(obs_y); it.by += 32'(obs_y);
        it.ang = 16'(q * 16384 + jit);
        return it;
    endfunction

    function automatic logic [15:0] fresh_id();
        logic [15:0] id;
        id = 16'($urandom);
        issued_ids.push_back(id);
        if (issued_ids.size() > 200) void'(issued_ids.pop_front());
        return id;
    endfunction

    function automatic t_seg_cmd random_cmd(input int remove_pct);
        t_seg_cmd it;
        int pick;
        pick = $urandom_range(99);
        if (pick < remove_pct) begin
            it = seg(rdas_pkg::CMD_REMOVE, 16'($urandom), $urandom, $urandom, $urandom,
                     $urandom, 16'($urandom));
            if (issued_ids.size() > 0 && $urandom_range(9) < 7)
                it.id = issued_ids[$urandom_range(issued_ids.size() - 1)];
        end else if (pick < remove_pct + 7) begin
            it = seg(rdas_pkg::CMD_QUERY, 16'($urandom), $urandom, $urandom, $urandom,
                     $urandom, 16'($urandom));
        end else if (pick < remove_pct + 9) begin
            it = seg(CMD_SPARE, 16'($urandom), $urandom, $urandom, $urandom,
                     $urandom, 16'($urandom));
        end else if (pick < remove_pct + 20) begin
            it = seg(rdas_pkg::CMD_INSERT, fresh_id(), $urandom, $urandom, $urandom,
                     $urandom, 16'($urandom));
        end else if ($urandom_range(7) == 0 && last_hit.cmd == rdas_pkg::CMD_INSERT) begin
            // same geometry again for equal distances
            it = last_hit;
            it.id = fresh_id();
        end else begin
            it = crossing_insert(fresh_id());
            last_hit = it;
        end
        return it;
    endfunction

    initial begin
        logic [31:0] ox [PHASES];
        logic [31:0] oy [PHASES];
        ox = '{32'h0, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0001_8000,
               32'hFFF0_0000, 32'h0, 32'h1234_5678, 32'hFFFF_FFFF};
        oy = '{32'h0, 32'h0, 32'h8000_0000, 32'hFFFE_4000,
               32'h7FFF_FFFF, 32'h8000_0000, 32'hEDCB_A988, 32'h0};
        run_live = 0; in_took = 0; err_count = 0; results_seen = 0;
        hold_asks = 0; hold_served = 0; hold_left = 0;
        send_idle = 0; rx_idle = 0; set_count = 0; obs_x = 0; obs_y = 0;
        last_hit.cmd = rdas_pkg::CMD_QUERY;
        i_rst_n = 0; i_valid = 0; i_stall = 0;
        i_command = rdas_pkg::CMD_QUERY; i_segment_id = 0; i_sweep_angle = 0;
        i_end_a_x = 0; i_end_a_y = 0; i_end_b_x = 0; i_end_b_y = 0;
        i_cfg_valid = 0; i_cfg_index = rdas_pkg::CFG_OBS_X; i_cfg_data = 0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        run_live = 1;

        reg_write(rdas_pkg::CFG_OBS_X, 32'h0);
        reg_write(rdas_pkg::CFG_OBS_Y, 32'h0);
        // directed opening
        pending_cmds.push_back(seg(rdas_pkg::CMD_QUERY, 16'h0, 0, 0, 0, 0, 0));
        pending_cmds.push_back(seg(rdas_pkg::CMD_REMOVE, 16'hFFFF, 0, 0, 0, 0, 0));
        pending_cmds.push_back(seg(rdas_pkg::CMD_INSERT, 16'h0011, 65536, 65536,
                                   65536, 65536, 0));
        pending_cmds.push_back(seg(rdas_pkg::CMD_INSERT, 16'h0012, 65536, 0,
                                   3 * 65536, 0, 0));
        pending_cmds.push_back(seg(rdas_pkg::CMD_INSERT, 16'h0013, 5 * 65536, -65536,
                                   5 * 65536, 65536, 0));
        pending_cmds.push_back(seg(rdas_pkg::CMD_INSERT, 16'h0014, -65536, 2 * 65536,
                                   65536, 2 * 65536, 16384));
        pending_cmds.push_back(seg(rdas_pkg::CMD_INSERT, 16'h0015, -3 * 65536, -65536,
                                   -3 * 65536, 65536, 32768));
        pending_cmds.push_back(seg(rdas_pkg::CMD_INSERT, 16'h0016, -65536, -7 * 65536,
                                   65536, -7 * 65536, 49152));
        pending_cmds.push_back(seg(rdas_pkg::CMD_INSERT, 16'h0017, -5 * 65536, -65536,
                                   -5 * 65536, 65536, 0));
        pending_cmds.push_back(seg(rdas_pkg::CMD_INSERT, 16'h0018, 5 * 65536, -65536,
                                   5 * 65536, 65536, 0));
        pending_cmds.push_back(seg(rdas_pkg::CMD_INSERT, 16'h0000, 65536, -65536,
                                   65536, 65536, 16'hFFFF));
        pending_cmds.push_back(seg(rdas_pkg::CMD_INSERT, 16'h0014, 2 * 65536, -65536,
                                   2 * 65536, 65536, 8192));
        pending_cmds.push_back(seg(rdas_pkg::CMD_INSERT, 16'hFFFF, 32'h7FFF_FFFF,
                                   32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
                                   16'h8000));
        pending_cmds.push_back(seg(rdas_pkg::CMD_REMOVE, 16'h0014, 0, 0, 0, 0, 0));
        pending_cmds.push_back(seg(rdas_pkg::CMD_REMOVE, 16'h0013, 0, 0, 0, 0, 0));
        pending_cmds.push_back(seg(rdas_pkg::CMD_REMOVE, 16'h1234, 0, 0, 0, 0, 0));
        pending_cmds.push_back(seg(CMD_SPARE, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                                   32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF));
        pending_cmds.push_back(seg(rdas_pkg::CMD_QUERY, 16'h5555, 0, 0, 0, 0, 0));
        drain();
        // far observer, nearly axial ray, distance saturates
        reg_write(rdas_pkg::CFG_OBS_X, 32'h8000_0000);
        pending_cmds.push_back(seg(rdas_pkg::CMD_INSERT, 16'h0BAD, 32'h7FFF_FFFF,
                                   32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                                   16'd1000));
        pending_cmds.push_back(seg(rdas_pkg::CMD_INSERT, 16'h0BAE, 32'h7FFF_FFFF,
                                   -65536, 32'h7FFF_FFFF, 65536, 16'd0));

        for (int p = 0; p < PHASES; p++) begin
            drain();
            repeat (DRAIN_WAIT) @(posedge i_clk);
            reg_write(rdas_pkg::CFG_OBS_X, ox[p]);
            reg_write(rdas_pkg::CFG_OBS_Y, oy[p]);
            case (p % 4)
                0: begin send_idle = 0;  rx_idle = 0;  end
                1: begin send_idle = 60; rx_idle = 0;  end
                2: begin send_idle = 0;  rx_idle = 60; end
                default: begin send_idle = 23; rx_idle = 23; end
            endcase
            // odd phases seldom remove, so the set fills and overflows
            for (int n = 0; n < PHASE_ITEMS; n++)
                pending_cmds.push_back(random_cmd((p % 2) ? 4 : 30));
            if (p == 0 || p == 5) hold_asks++;
        end
        drain();
        repeat (DRAIN_WAIT) @(posedge i_clk);
        $display("run covered %0d results over %0d observer settings and four idle mixes",
                 results_seen, PHASES + 2);
        $display("stored %0d, missed %0d, full %0d, removed %0d, not found/query %0d",
                 status_hits[0], status_hits[1], status_hits[2], status_hits[3],
                 status_hits[4]);
        if (err_count == 0) $display("DONE: 0 errors");
        else $display("DONE: errors detected");
        $finish;
    end
endmodule

`default_nettype wire
